// File: rtl/gamepad_event_to_key_bits_core_macros.svh
//------------------------------------------------------------------------------
// Gamepad event to key bits: assertion macros
// Shared concurrent assertion forms, clocked on clock and masked in reset.
//------------------------------------------------------------------------------
`ifndef GAMEPAD_EVENT_TO_KEY_BITS_CORE_MACROS_SVH
`define GAMEPAD_EVENT_TO_KEY_BITS_CORE_MACROS_SVH

// same-cycle implication
`define GEKB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gekb: same-cycle check failed");

// next-cycle implication
`define GEKB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gekb: next-cycle check failed");

`endif

// File: rtl/gekb_pkg.sv
//------------------------------------------------------------------------------
// Gamepad event to key bits: package
// Shared types, opcodes, button codes, key bits and the button map.
//------------------------------------------------------------------------------
`default_nettype none

package gekb_pkg;

   localparam int PadSlotsDefault = 3;
   localparam int MaxResults      = 4;
   localparam int CountW          = $clog2(MaxResults + 1);

   localparam logic [14:0] DeadzoneReset = 15'd16000;

   // opcodes
   localparam logic [2:0] OP_BTN_DOWN = 3'd0;
   localparam logic [2:0] OP_BTN_UP   = 3'd1;
   localparam logic [2:0] OP_AXIS     = 3'd2;
   localparam logic [2:0] OP_ATTACH   = 3'd3;
   localparam logic [2:0] OP_DETACH   = 3'd4;

   // buttons
   localparam logic [4:0] BTN_A          = 5'd0;
   localparam logic [4:0] BTN_B          = 5'd1;
   localparam logic [4:0] BTN_X          = 5'd2;
   localparam logic [4:0] BTN_Y          = 5'd3;
   localparam logic [4:0] BTN_BACK       = 5'd4;
   localparam logic [4:0] BTN_START      = 5'd6;
   localparam logic [4:0] BTN_SHOULDER_L = 5'd9;
   localparam logic [4:0] BTN_SHOULDER_R = 5'd10;
   localparam logic [4:0] BTN_DPAD_UP    = 5'd11;
   localparam logic [4:0] BTN_DPAD_RIGHT = 5'd14;

   // axes
   localparam logic [2:0] AXIS_LEFT_X = 3'd0;
   localparam logic [2:0] AXIS_LEFT_Y = 3'd1;

   // key bits
   localparam logic [15:0] KEY_A          = 16'h8000;
   localparam logic [15:0] KEY_B          = 16'h4000;
   localparam logic [15:0] KEY_X          = 16'h0080;
   localparam logic [15:0] KEY_Y          = 16'h0040;
   localparam logic [15:0] KEY_SHOULDER_L = 16'h0020;
   localparam logic [15:0] KEY_SHOULDER_R = 16'h0010;
   localparam logic [15:0] KEY_BACK       = 16'h2000;
   localparam logic [15:0] KEY_START      = 16'h1000;
   localparam logic [15:0] KEY_DIR_BASE   = 16'h0100;  // right; up is base << 3

   typedef struct packed {
      logic               [1:0]  pad_slot;
      logic               [2:0]  opcode;
      logic               [4:0]  button_code;
      logic               [2:0]  axis_code;
      logic signed        [15:0] axis_value;
   } item_type;

   // dpad: bit0 up .. bit3 right; dir: bit3 up .. bit0 right
   typedef struct packed {
      logic               attached;
      logic        [3:0]  dpad;
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic        [3:0]  dir;
   } slot_state_type;

   typedef struct packed {
      logic           wr_en;
      logic     [1:0] slot;
      slot_state_type state;
   } state_upd_type;

   typedef struct packed {
      logic [1:0]  player;
      logic [15:0] key_bits;
      logic        pressed;
   } result_type;

   typedef struct packed {
      logic [CountW-1:0]            count;
      result_type [MaxResults-1:0] entry;
   } result_set_type;

   function automatic logic [15:0] map_button(input logic [4:0] code);
      logic [15:0] kb;
      case (code)
         BTN_A:          kb = KEY_A;
         BTN_B:          kb = KEY_B;
         BTN_X:          kb = KEY_X;
         BTN_Y:          kb = KEY_Y;
         BTN_SHOULDER_L: kb = KEY_SHOULDER_L;
         BTN_SHOULDER_R: kb = KEY_SHOULDER_R;
         BTN_BACK:       kb = KEY_BACK;
         BTN_START:      kb = KEY_START;
         default:        kb = 16'h0000;
      endcase
      return kb;
   endfunction

endpackage

`default_nettype wire

// File: rtl/gekb_state.sv
//------------------------------------------------------------------------------
// Gamepad event to key bits: per-slot state
// Holds attach flag, d-pad flags, stick values and directions for each slot.
//------------------------------------------------------------------------------
`default_nettype none

module gekb_state
   import gekb_pkg::*;
#(
   parameter int PAD_SLOTS = PadSlotsDefault
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [1:0]     rd_slot,
   output slot_state_type      rd_state,
   input  wire state_upd_type  upd
);

   slot_state_type slot_ff [PAD_SLOTS];
   slot_state_type slot_in [PAD_SLOTS];

   always_comb begin
      rd_state = '0;
      for (int s = 0; s < PAD_SLOTS; s++) begin
         if (int'(rd_slot) == s) begin
            rd_state = slot_ff[s];
         end
      end
   end

   always_comb begin
      for (int s = 0; s < PAD_SLOTS; s++) begin
         slot_in[s] = slot_ff[s];
         if (upd.wr_en && int'(upd.slot) == s) begin
            slot_in[s] = upd.state;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < PAD_SLOTS; s++) begin
         if (reset) begin
            slot_ff[s] <= '0;
         end else begin
            slot_ff[s] <= slot_in[s];
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/gekb_decode.sv
//------------------------------------------------------------------------------
// Gamepad event to key bits: event decode
// One pass from the held event and slot state to a state update and results.
//------------------------------------------------------------------------------
`default_nettype none

module gekb_decode
   import gekb_pkg::*;
#(
   parameter int PAD_SLOTS = PadSlotsDefault
) (
   input  wire item_type        item,
   input  wire logic            fire,
   input  wire slot_state_type  cur,
   input  wire logic [14:0]     deadzone,
   output state_upd_type        upd,
   output result_set_type       rset
);

   logic                in_range;
   logic                recalc;
   logic [15:0]         kb;
   logic [1:0]          dpad_off;
   logic [3:0]          dpad_mask;
   logic signed [16:0]  dz_pos;
   logic signed [16:0]  dz_neg;
   logic signed [16:0]  sx;
   logic signed [16:0]  sy;
   logic [3:0]          nd;
   logic [3:0]          chg;
   logic [CountW-1:0]   n;
   slot_state_type      nxt;

   assign in_range  = int'(item.pad_slot) < PAD_SLOTS;
   assign kb        = map_button(item.button_code);
   assign dpad_off  = 2'(item.button_code - BTN_DPAD_UP);
   assign dpad_mask = 4'b0001 << dpad_off;
   assign dz_pos    = {2'b00, deadzone};
   assign dz_neg    = -dz_pos;

   always_comb begin
      nxt    = cur;
      recalc = 1'b0;
      upd    = '0;
      rset   = '0;
      nd     = '0;
      chg    = '0;
      n      = '0;
      sx     = '0;
      sy     = '0;
      upd.slot = item.pad_slot;

      if (fire && in_range) begin
         if (item.opcode == OP_ATTACH || item.opcode == OP_DETACH) begin
            upd.wr_en          = 1'b1;
            upd.state          = '0;
            upd.state.attached = (item.opcode == OP_ATTACH);
         end else if (cur.attached) begin
            if (item.opcode == OP_BTN_DOWN || item.opcode == OP_BTN_UP) begin
               if (item.button_code inside {[BTN_DPAD_UP:BTN_DPAD_RIGHT]}) begin
                  recalc = 1'b1;
                  if (item.opcode == OP_BTN_DOWN) begin
                     nxt.dpad = cur.dpad | dpad_mask;
                  end else begin
                     nxt.dpad = cur.dpad & ~dpad_mask;
                  end
               end else if (kb != 16'h0000) begin
                  rset.count                = CountW'(1);
                  rset.entry[0].player      = item.pad_slot;
                  rset.entry[0].key_bits    = kb;
                  rset.entry[0].pressed     = (item.opcode == OP_BTN_DOWN);
               end
            end else if (item.opcode == OP_AXIS) begin
               if (item.axis_code == AXIS_LEFT_X) begin
                  recalc      = 1'b1;
                  nxt.stick_x = item.axis_value;
               end else if (item.axis_code == AXIS_LEFT_Y) begin
                  recalc      = 1'b1;
                  nxt.stick_y = item.axis_value;
               end
            end
         end
      end

      if (recalc) begin
         sx    = {nxt.stick_x[15], nxt.stick_x};
         sy    = {nxt.stick_y[15], nxt.stick_y};
         nd[3] = nxt.dpad[0] || (sy < dz_neg);
         nd[2] = nxt.dpad[1] || (sy > dz_pos);
         nd[1] = nxt.dpad[2] || (sx < dz_neg);
         nd[0] = nxt.dpad[3] || (sx > dz_pos);
         chg   = nd ^ cur.dir;
         nxt.dir   = nd;
         upd.wr_en = 1'b1;
         upd.state = nxt;
         // emit changed directions up, down, left, right
         for (int i = 3; i >= 0; i--) begin
            if (chg[i]) begin
               rset.entry[n[1:0]].player   = item.pad_slot;
               rset.entry[n[1:0]].key_bits = KEY_DIR_BASE << i;
               rset.entry[n[1:0]].pressed  = nd[i];
               n = n + CountW'(1);
            end
         end
         rset.count = n;
      end
   end

endmodule

`default_nettype wire

// File: rtl/gekb_out.sv
//------------------------------------------------------------------------------
// Gamepad event to key bits: result buffer
// Holds one event's results; hands out one beat per cycle while out_ready.
//------------------------------------------------------------------------------
`default_nettype none

`include "gamepad_event_to_key_bits_core_macros.svh"

module gekb_out
   import gekb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire result_set_type  rset,
   output logic                 can_load,
   output logic                 out_valid,
   output logic                 out_last,
   output result_type           head,
   input  wire logic            out_ready
);

   result_type [MaxResults-1:0] queue_ff;
   result_type [MaxResults-1:0] queue_in;
   logic       [CountW-1:0]     count_ff;
   logic       [CountW-1:0]     count_in;
   logic                        pop;

   assign out_valid = (count_ff != '0);
   assign out_last  = (count_ff == CountW'(1));
   assign head      = queue_ff[0];
   assign pop       = out_valid && out_ready;
   assign can_load  = (count_ff == '0) || (out_last && out_ready);

   always_comb begin
      queue_in = queue_ff;
      count_in = count_ff;
      if (load) begin
         queue_in = rset.entry;
         count_in = rset.count;
      end else if (pop) begin
         for (int k = 0; k < MaxResults - 1; k++) begin
            queue_in[k] = queue_ff[k+1];
         end
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   `GEKB_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CountW'(MaxResults))
   `GEKB_ASSERT_NOW(a_load_safe, load, (count_ff == '0) || (out_last && pop))
   `GEKB_ASSERT_NEXT(a_pop_drains, pop && !load, count_ff == $past(count_ff) - CountW'(1))

endmodule

`default_nettype wire

// File: rtl/gamepad_event_to_key_bits_core.sv
//------------------------------------------------------------------------------
// Gamepad event to key bits: top level
// Flow: an accepted event waits in the input register until the result buffer
//   can take its results; the buffer then holds them as result beats.
// Throughput: one event per cycle when it yields at most one result and the
//   receiver is ready; an event with n results (at most 4) holds the input
//   while the buffer drains one beat per cycle, when the receiver is ready.
// Reset: clears all slots (detached), both stages, and loads deadzone 16000.
//------------------------------------------------------------------------------
`default_nettype none

module gamepad_event_to_key_bits_core
   import gekb_pkg::*;
#(
   parameter int PAD_SLOTS = PadSlotsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // event in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] pad_slot, [4:2] opcode, [9:5] button_code, [12:10] axis_code,
   // [28:13] axis_value, [31:29] zero
   input  wire logic [31:0] req_tdata,
   // key event out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] player, [17:2] key_bits, [18] pressed, [23:19] zero
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   // deadzone register
   input  wire logic        csr_wr_en,
   input  wire logic [14:0] csr_wr_data
);

   // Stage 1: input register. Stage 2 is the decode pass that loads the
   // result buffer and writes the slot state on the same edge (advance).
   logic           in_valid_ff;
   logic           in_valid_in;
   item_type       in_item_ff;
   logic [14:0]    deadzone_ff;
   logic           advance;
   logic           can_load;
   slot_state_type cur_state;
   state_upd_type  upd;
   result_set_type rset;
   result_type     head;
   item_type       req_item;

   assign req_item.pad_slot    = req_tdata[1:0];
   assign req_item.opcode      = req_tdata[4:2];
   assign req_item.button_code = req_tdata[9:5];
   assign req_item.axis_code   = req_tdata[12:10];
   assign req_item.axis_value  = req_tdata[28:13];

   // held event moves on as soon as the buffer can take its results
   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         deadzone_ff <= DeadzoneReset;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            deadzone_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
   end

   gekb_state #(
      .PAD_SLOTS (PAD_SLOTS)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (in_item_ff.pad_slot),
      .rd_state (cur_state),
      .upd      (upd)
   );

   gekb_decode #(
      .PAD_SLOTS (PAD_SLOTS)
   ) u_decode (
      .item     (in_item_ff),
      .fire     (advance),
      .cur      (cur_state),
      .deadzone (deadzone_ff),
      .upd      (upd),
      .rset     (rset)
   );

   gekb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rset      (rset),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_last  (rsp_tlast),
      .head      (head),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {5'd0, head.pressed, head.key_bits, head.player};

endmodule

`default_nettype wire
